// File: sv/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Opcodes, status codes and controller states shared by the step executor.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE = 7'd0;
   localparam logic [6:0] F7_ALT  = 7'd32;

   localparam logic [4:0] REG_A0 = 5'd10;
   localparam logic [4:0] REG_A7 = 5'd17;

   localparam logic [31:0] CALL_PRINT_INT = 32'd1;
   localparam logic [31:0] CALL_PRINT_STR = 32'd4;
   localparam logic [31:0] CALL_EXIT      = 32'd10;

   localparam logic [16:0] PC_LIMIT_RESET = 17'd16000;

   typedef enum logic [2:0] {
      ST_EXECUTED  = 3'd0,
      ST_UNKNOWN   = 3'd1,
      ST_PRINT_INT = 3'd2,
      ST_PRINT_STR = 3'd3,
      ST_EXIT      = 3'd4,
      ST_STOPPED   = 3'd5,
      ST_PRELOAD   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_LOAD
   } state_type;

endpackage

`default_nettype wire

// File: sv/rse_ram.sv
// ----------------------------------------------------------------------------
// rse_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: sv/rv32i_step_executor.sv
// ----------------------------------------------------------------------------
// rv32i_step_executor
// RV32I executor stepping one instruction per request, with byte preload.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready): mode 1 writes preload_byte at preload_address,
//   mode 0 fetches the word at pc and executes it. One rsp item per request.
//   csr_we/csr_wdata write pc_limit at any edge; write only while idle.
// Steps: a preload writes its byte and loads the result register on accept;
//   a step passes S_FETCH, which loads the result if it stops, then S_EXEC,
//   which loads it for all but a known load, then S_LOAD for such a load,
//   following the registered reads of the banked memory fetch, the register
//   file and the load. One preload per cycle while the result slot drains;
//   steps do not overlap. A new request is taken once the result slot is
//   empty or being drained in the same cycle.
// Reset: pc and pc_limit return to their reset values, then a clearing pass
//   over the MEM_BYTES/4 rows zeroes memory and register file; req_ready is
//   low during that pass.
// Stall: a held result sits in the output register until rsp_ready.
// Memory: four byte banks of MEM_BYTES/4 rows (MEM_BYTES a power of two).
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_step_executor
   import rse_pkg::*;
#(
   parameter int MEM_BYTES = 131072
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [16:0] req_preload_address,
   input  wire logic [7:0]  req_preload_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_instr_address,
   output logic [31:0]      rsp_instr_word,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_dest_written,
   output logic [31:0]      rsp_next_pc,
   output logic [31:0]      rsp_call_value,
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int ROW_W  = ADDR_W - 2;
   localparam int ROWS   = MEM_BYTES / 4;

   state_type state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic [31:0] pc_ff, pc_in;
   logic [16:0] limit_ff;
   logic [31:0] w_ff, w_in;
   logic [1:0]  off_ff, off_in;

   logic        rv_ff;
   logic [31:0] ia_ff, iw_ff, dv_ff, np_ff, cv_ff;
   logic [2:0]  st_ff;
   logic [4:0]  di_ff;
   logic        dw_ff;

   logic        o_load;
   logic [31:0] o_ia, o_iw, o_dv, o_np, o_cv;
   status_type  o_st;
   logic [4:0]  o_di;
   logic        o_dw;

   logic             bk_we    [4];
   logic [ROW_W-1:0] bk_waddr [4];
   logic [7:0]       bk_wdata [4];
   logic [ROW_W-1:0] bk_raddr [4];
   logic [7:0]       bk_rdata [4];

   logic        rf_we;
   logic [4:0]  rf_waddr, rf_ra, rf_rb;
   logic [31:0] rf_wdata, r1, r2;

   logic [31:0]       mem_word;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       pre_addr;
   logic              accept;

   logic [6:0]  op, f7;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, alu_b, val, npc, ea;
   logic [4:0]  sh;
   logic        wr, unk, take, stop;
   logic [1:0]  lane;
   logic [32:0] pc_end;

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_bank
         rse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .clock (clock),
            .we    (bk_we[g]),
            .waddr (bk_waddr[g]),
            .wdata (bk_wdata[g]),
            .raddr (bk_raddr[g]),
            .rdata (bk_rdata[g])
         );
      end
   endgenerate

   rse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock (clock),
      .we    (rf_we),
      .waddr (rf_waddr),
      .wdata (rf_wdata),
      .raddr (rf_ra),
      .rdata (r1)
   );

   rse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock (clock),
      .we    (rf_we),
      .waddr (rf_waddr),
      .wdata (rf_wdata),
      .raddr (rf_rb),
      .rdata (r2)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign pre_addr  = {15'd0, req_preload_address};

   // bank read rows: banks below the offset come from the next row
   always_comb begin
      rd_addr = (state_ff == S_EXEC) ? ea[ADDR_W-1:0] : pc_ff[ADDR_W-1:0];
      for (int b = 0; b < 4; b++) begin
         bk_raddr[b] = (2'(b) < rd_addr[1:0]) ? rd_addr[ADDR_W-1:2] + 1'b1
                                             : rd_addr[ADDR_W-1:2];
      end
      for (int i = 0; i < 4; i++) begin
         mem_word[8*i +: 8] = bk_rdata[2'(off_ff + 2'(i))];
      end
   end

   always_comb begin
      op    = w_ff[6:0];
      rd    = w_ff[11:7];
      f3    = w_ff[14:12];
      f7    = w_ff[31:25];
      imm_i = {{20{w_ff[31]}}, w_ff[31:20]};
      imm_s = {{20{w_ff[31]}}, w_ff[31:25], w_ff[11:7]};
      imm_b = {{20{w_ff[31]}}, w_ff[7], w_ff[30:25], w_ff[11:8], 1'b0};
      imm_j = {{12{w_ff[31]}}, w_ff[19:12], w_ff[20], w_ff[30:21], 1'b0};
      alu_b = (op == OP_REG) ? r2 : imm_i;
      sh    = alu_b[4:0];
      ea    = r1 + ((op == OP_STORE) ? imm_s : imm_i);
      pc_end = {1'b0, pc_ff} + 33'd4;
      stop  = (mem_word == 32'd0) || (pc_end > {16'd0, limit_ff});

      state_in = state_ff;
      clr_in   = clr_ff;
      pc_in    = pc_ff;
      w_in     = w_ff;
      off_in   = off_ff;

      o_load = 1'b0;
      o_ia = pc_ff;
      o_iw = w_ff;
      o_st = ST_EXECUTED;
      o_di = 5'd0;
      o_dv = 32'd0;
      o_dw = 1'b0;
      o_np = pc_ff;
      o_cv = 32'd0;

      for (int b = 0; b < 4; b++) begin
         bk_we[b]    = 1'b0;
         bk_waddr[b] = pre_addr[ADDR_W-1:2];
         bk_wdata[b] = req_preload_byte;
      end
      rf_we    = 1'b0;
      rf_waddr = rd;
      rf_wdata = 32'd0;
      rf_ra    = (mem_word[6:0] == OP_SYSTEM) ? REG_A7 : mem_word[19:15];
      rf_rb    = (mem_word[6:0] == OP_SYSTEM) ? REG_A0 : mem_word[24:20];

      val  = 32'd0;
      npc  = pc_ff + 32'd4;
      wr   = 1'b0;
      unk  = 1'b0;
      take = 1'b0;
      lane = 2'd0;

      case (state_ff)
         S_CLEAR: begin
            for (int b = 0; b < 4; b++) begin
               bk_we[b]    = 1'b1;
               bk_waddr[b] = clr_ff;
               bk_wdata[b] = 8'd0;
            end
            rf_we    = 1'b1;
            rf_waddr = clr_ff[4:0];
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == {ROW_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            off_in = pc_ff[1:0];
            if (accept) begin
               if (req_mode) begin
                  for (int b = 0; b < 4; b++) begin
                     bk_we[b] = (pre_addr[1:0] == 2'(b));
                  end
                  o_load = 1'b1;
                  o_ia   = 32'd0;
                  o_iw   = 32'd0;
                  o_st   = ST_PRELOAD;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            w_in = mem_word;
            if (stop) begin
               o_load   = 1'b1;
               o_iw     = mem_word;
               o_st     = ST_STOPPED;
               state_in = S_IDLE;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            off_in = ea[1:0];
            case (op)
               OP_REG, OP_IMM: begin
                  wr = 1'b1;
                  case (f3)
                     3'd0: begin
                        if (op == OP_IMM || f7 == F7_BASE) val = r1 + alu_b;
                        else if (f7 == F7_ALT) val = r1 - alu_b;
                        else unk = 1'b1;
                     end
                     3'd1: val = r1 << sh;
                     3'd2: val = {31'd0, $signed(r1) < $signed(alu_b)};
                     3'd3: val = {31'd0, r1 < alu_b};
                     3'd4: val = r1 ^ alu_b;
                     3'd5: begin
                        if (f7 == F7_BASE) val = r1 >> sh;
                        else if (f7 == F7_ALT) val = $unsigned($signed(r1) >>> sh);
                        else unk = 1'b1;
                     end
                     3'd6: val = r1 | alu_b;
                     default: val = r1 & alu_b;
                  endcase
               end
               OP_LOAD: begin
                  wr = 1'b1;
                  if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) unk = 1'b1;
               end
               OP_STORE: begin
                  if (f3 > 3'd2) begin
                     unk = 1'b1;
                  end else begin
                     for (int b = 0; b < 4; b++) begin
                        lane = 2'(b) - ea[1:0];
                        bk_we[b]    = (lane == 2'd0) || (f3 == 3'd2) ||
                                      (f3 == 3'd1 && lane == 2'd1);
                        bk_waddr[b] = bk_raddr[b];
                        bk_wdata[b] = r2[8*lane +: 8];
                     end
                  end
               end
               OP_BRANCH: begin
                  case (f3)
                     3'd0: take = (r1 == r2);
                     3'd1: take = (r1 != r2);
                     3'd4: take = $signed(r1) < $signed(r2);
                     3'd5: take = !($signed(r1) < $signed(r2));
                     3'd6: take = r1 < r2;
                     3'd7: take = r1 >= r2;
                     default: take = 1'b0;
                  endcase
                  if (take) npc = pc_ff + imm_b;
               end
               OP_JAL: begin
                  wr  = 1'b1;
                  val = pc_ff + 32'd4;
                  npc = pc_ff + imm_j;
               end
               OP_JALR: begin
                  wr  = 1'b1;
                  val = pc_ff + 32'd4;
                  npc = (r1 + imm_i) & 32'hFFFF_FFFE;
               end
               OP_LUI: begin
                  wr  = 1'b1;
                  val = {w_ff[31:12], 12'd0};
               end
               OP_AUIPC: begin
                  wr  = 1'b1;
                  val = pc_ff + {w_ff[31:12], 12'd0};
               end
               OP_SYSTEM: begin
                  if (r1 == CALL_PRINT_INT) begin
                     o_st = ST_PRINT_INT;
                     o_cv = r2;
                  end else if (r1 == CALL_PRINT_STR) begin
                     o_st = ST_PRINT_STR;
                     o_cv = r2;
                  end else if (r1 == CALL_EXIT) begin
                     o_st = ST_EXIT;
                  end else begin
                     o_st = ST_UNKNOWN;
                  end
               end
               default: unk = 1'b1;
            endcase
            if (unk) begin
               o_st = ST_UNKNOWN;
               wr   = 1'b0;
               val  = 32'd0;
            end
            pc_in = npc;
            o_np  = npc;
            if (op == OP_LOAD && !unk) begin
               state_in = S_LOAD;
            end else begin
               o_load   = 1'b1;
               o_di     = wr ? rd : 5'd0;
               o_dv     = val;
               o_dw     = wr && (rd != 5'd0);
               rf_we    = o_dw;
               rf_wdata = val;
               state_in = S_IDLE;
            end
         end
         S_LOAD: begin
            case (f3)
               3'd0: val = {{24{mem_word[7]}}, mem_word[7:0]};
               3'd1: val = {{16{mem_word[15]}}, mem_word[15:0]};
               3'd4: val = {24'd0, mem_word[7:0]};
               3'd5: val = {16'd0, mem_word[15:0]};
               default: val = mem_word;
            endcase
            o_load   = 1'b1;
            o_di     = rd;
            o_dv     = val;
            o_dw     = (rd != 5'd0);
            o_ia     = pc_ff - 32'd4;
            rf_we    = o_dw;
            rf_wdata = val;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= 32'd0;
         limit_ff <= PC_LIMIT_RESET;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (o_load) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      off_ff <= off_in;
      if (o_load) begin
         ia_ff <= o_ia;
         iw_ff <= o_iw;
         st_ff <= o_st;
         di_ff <= o_di;
         dv_ff <= o_dv;
         dw_ff <= o_dw;
         np_ff <= o_np;
         cv_ff <= o_cv;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_instr_address = ia_ff;
   assign rsp_instr_word    = iw_ff;
   assign rsp_status        = st_ff;
   assign rsp_dest_index    = di_ff;
   assign rsp_dest_value    = dv_ff;
   assign rsp_dest_written  = dw_ff;
   assign rsp_next_pc       = np_ff;
   assign rsp_call_value    = cv_ff;

endmodule

`default_nettype wire
